FILE: design/lnx_pkg.sv
// shared types and constants for the rv32i lane executor
// no dependencies; imported by every module of the block
package lnx_pkg;

    // request kinds on the input channel
    typedef enum logic [1:0] {
        OP_EXEC    = 2'd0,
        OP_HOST_WR = 2'd1,
        OP_HOST_RD = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    // memory access size
    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } t_size;

    // major opcodes
    localparam logic [6:0] OPC_LOAD    = 7'h03;
    localparam logic [6:0] OPC_LOADFP  = 7'h07;
    localparam logic [6:0] OPC_OPIMM   = 7'h13;
    localparam logic [6:0] OPC_AUIPC   = 7'h17;
    localparam logic [6:0] OPC_STORE   = 7'h23;
    localparam logic [6:0] OPC_STOREFP = 7'h27;
    localparam logic [6:0] OPC_OP      = 7'h33;
    localparam logic [6:0] OPC_LUI     = 7'h37;
    localparam logic [6:0] OPC_BRANCH  = 7'h63;
    localparam logic [6:0] OPC_JALR    = 7'h67;
    localparam logic [6:0] OPC_JAL     = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM  = 7'h73;
    localparam logic [6:0] F7_ALT      = 7'h20;
    localparam logic [6:0] F7_ZERO     = 7'h00;

    // alu funct3
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // branch funct3
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // load / store funct3
    localparam logic [2:0] F3_B    = 3'd0;
    localparam logic [2:0] F3_H    = 3'd1;
    localparam logic [2:0] F3_W    = 3'd2;
    localparam logic [2:0] F3_BU   = 3'd4;
    localparam logic [2:0] F3_HU   = 3'd5;

    localparam logic [4:0] REG_LINK = 5'd1;
    localparam logic [4:0] REG_EXIT = 5'd17;
    localparam logic [4:0] REG_ZERO = 5'd0;

    // decoded effect of one instruction
    typedef struct packed {
        logic        rf_we;
        logic [4:0]  rf_wa;
        logic [31:0] rf_wd;
        logic [31:0] next_pc;
        logic        mem_rd;
        logic        mem_rd_float;
        logic        mem_we;
        t_size       mem_size;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
    } t_exec_res;

endpackage

FILE: design/lnx_regfile.sv
// 32 x 32 register file with synchronous reads, valid bits and write bypass
// depends on lnx_pkg
module lnx_regfile
    import lnx_pkg::*;
#(
    parameter int N_RD = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rd_en,
    input  logic [4:0]  i_ra [N_RD],
    output logic [31:0] o_rd [N_RD],
    input  logic        i_clr,
    input  logic        i_we,
    input  logic [4:0]  i_wa,
    input  logic [31:0] i_wd
);

    logic [31:0] r_mem [32];
    logic [31:0] r_valid;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // valid bits: cleared on reset and restart, set by writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_clr) begin
                r_valid <= '0;
            end
            if (i_we) begin
                r_valid[i_wa] <= 1'b1;
            end
        end
    end

    // read ports with bypass of a same-edge write or clear
    for (genvar gp = 0; gp < N_RD; gp++) begin : g_port
        logic [31:0] r_q;
        logic        r_byp;
        logic [31:0] r_byp_val;

        always_ff @(posedge i_clk) begin
            if (i_rd_en) begin
                r_q <= r_mem[i_ra[gp]];
                if (i_we && i_wa == i_ra[gp]) begin
                    r_byp     <= 1'b1;
                    r_byp_val <= i_wd;
                end else if (i_clr || !r_valid[i_ra[gp]]) begin
                    r_byp     <= 1'b1;
                    r_byp_val <= '0;
                end else begin
                    r_byp     <= 1'b0;
                    r_byp_val <= '0;
                end
            end
        end

        assign o_rd[gp] = r_byp ? r_byp_val : r_q;
    end

endmodule

FILE: design/lnx_dmem.sv
// byte-addressed data memory as four byte lanes, unaligned wrapping access
// depends on lnx_pkg
module lnx_dmem
    import lnx_pkg::*;
#(
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_size             i_size,
    input  logic [31:0]       i_wdata,
    output logic [31:0]       o_rdata
);

    localparam int WAW   = ADDR_W - 2;
    localparam int WORDS = 1 << WAW;

    logic [1:0]     a0;
    logic [WAW-1:0] widx;
    logic [2:0]     nbytes;
    logic [1:0]     r_a0;
    logic [7:0]     lane_q [4];

    assign a0   = i_addr[1:0];
    assign widx = i_addr[ADDR_W-1:2];

    // bytes written per size
    always_comb begin
        case (i_size)
            SZ_BYTE: nbytes = 3'd1;
            SZ_HALF: nbytes = 3'd2;
            SZ_WORD: nbytes = 3'd4;
            default: nbytes = 3'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_a0 <= a0;
        end
    end

    // one memory per byte lane; lanes below the start offset use the next word
    for (genvar gl = 0; gl < 4; gl++) begin : g_lane
        logic [7:0]     r_mem [WORDS];
        logic [7:0]     r_q;
        logic [1:0]     k;
        logic [WAW-1:0] wi;
        logic           we;

        assign k  = 2'(2'(gl) - a0);
        assign wi = widx + WAW'(2'(gl) < a0);
        assign we = i_wr_en && ({1'b0, k} < nbytes);

        always_ff @(posedge i_clk) begin
            if (we) begin
                r_mem[wi] <= i_wdata[8*k +: 8];
            end
            if (i_rd_en) begin
                r_q <= r_mem[wi];
            end
        end

        assign lane_q[gl] = r_q;
    end

    // reassemble little-endian word from the rotated lanes
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_rdata[8*k +: 8] = lane_q[2'(r_a0 + 2'(k))];
        end
    end

endmodule

FILE: design/lnx_exec.sv
// instruction decode and execute: alu, branch, address and writeback select
// depends on lnx_pkg
module lnx_exec
    import lnx_pkg::*;
(
    input  logic [31:0] i_instr,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_rs1,
    input  logic [31:0] i_rs2,
    input  logic [31:0] i_frs2,
    output t_exec_res   o_res
);

    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1_f;
    logic [6:0]  f7;
    logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
    logic [31:0] link;
    logic        is_imm;
    logic [31:0] y;
    logic [4:0]  sh;
    logic [31:0] alu;
    logic        take;

    assign opcode = i_instr[6:0];
    assign rd     = i_instr[11:7];
    assign f3     = i_instr[14:12];
    assign rs1_f  = i_instr[19:15];
    assign f7     = i_instr[31:25];
    assign imm_i  = {{20{i_instr[31]}}, i_instr[31:20]};
    assign imm_s  = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign imm_b  = {{19{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                     i_instr[11:8], 1'b0};
    assign imm_u  = {i_instr[31:12], 12'd0};
    assign imm_j  = {{11{i_instr[31]}}, i_instr[31], i_instr[19:12], i_instr[20],
                     i_instr[30:21], 1'b0};
    assign link   = i_pc + 32'd4;

    // integer alu for op and op-imm
    assign is_imm = (opcode == OPC_OPIMM);
    assign y      = is_imm ? imm_i : i_rs2;
    assign sh     = is_imm ? i_instr[24:20] : i_rs2[4:0];

    always_comb begin
        case (f3)
            F3_ADD:  alu = (!is_imm && f7 == F7_ALT) ? i_rs1 - y : i_rs1 + y;
            F3_SLL:  alu = i_rs1 << sh;
            F3_SLT:  alu = {31'd0, $signed(i_rs1) < $signed(y)};
            F3_SLTU: alu = {31'd0, i_rs1 < y};
            F3_XOR:  alu = i_rs1 ^ y;
            F3_SR:   alu = (f7 == F7_ZERO) ? i_rs1 >> sh
                                           : 32'($signed(i_rs1) >>> sh);
            F3_OR:   alu = i_rs1 | y;
            default: alu = i_rs1 & y;
        endcase
    end

    // branch condition
    always_comb begin
        case (f3)
            F3_BEQ:  take = (i_rs1 == i_rs2);
            F3_BNE:  take = (i_rs1 != i_rs2);
            F3_BLT:  take = $signed(i_rs1) < $signed(i_rs2);
            F3_BGE:  take = !($signed(i_rs1) < $signed(i_rs2));
            F3_BLTU: take = (i_rs1 < i_rs2);
            F3_BGEU: take = (i_rs1 >= i_rs2);
            default: take = 1'b0;
        endcase
    end

    // per-opcode effect
    always_comb begin
        o_res              = '0;
        o_res.rf_wa        = rd;
        o_res.next_pc      = link;
        o_res.mem_size     = SZ_WORD;
        o_res.mem_addr     = i_rs1 + imm_i;
        o_res.mem_wdata    = i_rs2;
        unique case (opcode) inside
            OPC_LUI: begin
                o_res.rf_we = 1'b1;
                o_res.rf_wd = imm_u;
            end
            OPC_AUIPC: begin
                o_res.rf_we = 1'b1;
                o_res.rf_wd = i_pc + imm_u;
            end
            OPC_JAL: begin
                o_res.rf_we   = 1'b1;
                o_res.rf_wd   = link;
                o_res.next_pc = i_pc + imm_j;
            end
            OPC_JALR: begin
                o_res.rf_we   = 1'b1;
                o_res.rf_wd   = link;
                o_res.next_pc = (i_rs1 + imm_i) & ~32'd1;
            end
            OPC_BRANCH: begin
                if (take) begin
                    o_res.next_pc = i_pc + imm_b;
                end
            end
            OPC_LOAD: begin
                o_res.mem_rd = 1'b1;
            end
            OPC_LOADFP: begin
                o_res.mem_rd       = 1'b1;
                o_res.mem_rd_float = 1'b1;
            end
            OPC_STORE: begin
                o_res.mem_addr = i_rs1 + imm_s;
                o_res.mem_we   = (f3 == F3_B) || (f3 == F3_H) || (f3 == F3_W);
                case (f3)
                    F3_B:    o_res.mem_size = SZ_BYTE;
                    F3_H:    o_res.mem_size = SZ_HALF;
                    default: o_res.mem_size = SZ_WORD;
                endcase
            end
            OPC_STOREFP: begin
                o_res.mem_addr  = i_rs1 + imm_s;
                o_res.mem_wdata = i_frs2;
                o_res.mem_we    = (f3 == F3_W);
            end
            OPC_OPIMM, OPC_OP: begin
                o_res.rf_we = 1'b1;
                o_res.rf_wd = alu;
            end
            OPC_SYSTEM: begin
                // exit form sets x17 to one
                if (rd == REG_ZERO && rs1_f == REG_ZERO && f3 == 3'd0) begin
                    o_res.rf_we = 1'b1;
                    o_res.rf_wa = REG_EXIT;
                    o_res.rf_wd = 32'd1;
                end
            end
            default: begin
            end
        endcase
        // x0 is never written
        if (o_res.rf_wa == REG_ZERO) begin
            o_res.rf_we = 1'b0;
        end
    end

endmodule

FILE: design/rv32i_lane_executor.sv
// rv32i lane executor top level: request pipeline, state, result register
// depends on lnx_pkg, lnx_regfile, lnx_dmem, lnx_exec
//
// Usage:
//  - input channel (i_valid/o_ready): one request per handshake; op selects
//    execute (instr fetched at the current pc), host word write, host word
//    read, or lane restart
//  - output channel (o_valid/i_ready): exactly one result per request, in
//    order: next pc, lane active flag, executed flag and host read data
//  - config channel (i_cfg_valid/o_cfg_ready): index 0 start pc, index 1
//    thread index; always ready, write only while no request is in flight
//  - a result is registered from stage 1, or for loads and host reads from
//    stage 2 once the data memory lanes have returned the read data
//  - throughput: one request per cycle while the receiver keeps up; a load or
//    host read holds o_ready low while it moves into stage 2
//  - register file reads are issued at accept; a write committing in the
//    same cycle is bypassed, so back-to-back dependent instructions work
//  - reset clears pc, registers and the active flag; memory is not cleared
//  - when the receiver stalls, the result register holds and at most one more
//    request waits inside before o_ready drops
module rv32i_lane_executor
    import lnx_pkg::*;
#(
    parameter int DATA_MEM_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_instr,
    input  logic [11:0] i_host_addr,
    input  logic [31:0] i_host_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_next_pc,
    output logic        o_lane_active,
    output logic        o_executed,
    output logic [31:0] o_read_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(DATA_MEM_BYTES);

    // configuration
    logic [31:0] r_start_pc, r_thread_index;

    // architectural state
    logic [31:0] r_pc;
    logic        r_running;
    logic        r_x17_one;

    // stage 1: register read done, execute
    logic        r_s1_v;
    logic [1:0]  r_s1_op;
    logic [31:0] r_s1_instr;
    logic [11:0] r_s1_haddr;
    logic [31:0] r_s1_hdata;

    // stage 2: waiting on memory read data
    logic        r_s2_v;
    logic        r_s2_host;
    logic        r_s2_float;
    logic [2:0]  r_s2_f3;
    logic [4:0]  r_s2_rd;

    // result register
    logic        r_ov;
    logic [31:0] r_o_pc;
    logic        r_o_active;
    logic        r_o_exec;
    logic [31:0] r_o_rdata;

    logic        accept, out_free, fire1, fire2, move12;
    t_op         s1_op;
    logic        exec_live, s1_needs_rd, s1_host;
    t_exec_res   res;
    logic [4:0]  int_ra [2];
    logic [31:0] int_rd [2];
    logic [4:0]  fp_ra [1];
    logic [31:0] fp_rd [1];
    logic        clr;
    logic        int_we, fp_we;
    logic [4:0]  int_wa;
    logic [31:0] int_wd;
    logic [31:0] mem_q, ld_val;
    logic        ld_ok;
    logic        dm_we;
    logic [31:0] dm_addr32;
    logic        n_x17_one, n_running, done_exec;
    logic [31:0] n_pc;

    // handshake
    assign s1_op     = t_op'(r_s1_op);
    assign exec_live = (s1_op == OP_EXEC) && r_running;
    assign s1_host   = (s1_op == OP_HOST_WR) || (s1_op == OP_HOST_RD);
    assign out_free  = !r_ov || i_ready;
    assign s1_needs_rd = r_s1_v && ((exec_live && res.mem_rd) || s1_op == OP_HOST_RD);
    assign fire1     = r_s1_v && !s1_needs_rd && out_free;
    assign move12    = s1_needs_rd && !r_s2_v;
    assign fire2     = r_s2_v && out_free;
    assign o_ready   = (!r_s1_v || fire1) && (!r_s2_v || fire2);
    assign accept    = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pc     <= '0;
            r_thread_index <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index) begin
                r_thread_index <= i_cfg_data;
            end else begin
                r_start_pc <= i_cfg_data;
            end
        end
    end

    // register files, read at accept
    assign int_ra[0] = i_instr[19:15];
    assign int_ra[1] = i_instr[24:20];
    assign fp_ra[0]  = i_instr[24:20];

    lnx_regfile #(.N_RD(2)) u_int_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept),
        .i_ra    (int_ra),
        .o_rd    (int_rd),
        .i_clr   (clr),
        .i_we    (int_we),
        .i_wa    (int_wa),
        .i_wd    (int_wd)
    );

    lnx_regfile #(.N_RD(1)) u_fp_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept),
        .i_ra    (fp_ra),
        .o_rd    (fp_rd),
        .i_clr   (clr),
        .i_we    (fp_we),
        .i_wa    (r_s2_rd),
        .i_wd    (mem_q)
    );

    lnx_exec u_exec (
        .i_instr (r_s1_instr),
        .i_pc    (r_pc),
        .i_rs1   (int_rd[0]),
        .i_rs2   (int_rd[1]),
        .i_frs2  (fp_rd[0]),
        .o_res   (res)
    );

    // data memory port
    assign dm_we     = fire1 && ((exec_live && res.mem_we) || s1_op == OP_HOST_WR);
    assign dm_addr32 = s1_host ? 32'(r_s1_haddr) : res.mem_addr;

    lnx_dmem #(.ADDR_W(ADDR_W)) u_dmem (
        .i_clk   (i_clk),
        .i_rd_en (move12),
        .i_wr_en (dm_we),
        .i_addr  (dm_addr32[ADDR_W-1:0]),
        .i_size  (s1_host ? SZ_WORD : res.mem_size),
        .i_wdata (s1_host ? r_s1_hdata : res.mem_wdata),
        .o_rdata (mem_q)
    );

    // load extension
    always_comb begin
        ld_ok = 1'b1;
        case (r_s2_f3)
            F3_B:    ld_val = {{24{mem_q[7]}}, mem_q[7:0]};
            F3_H:    ld_val = {{16{mem_q[15]}}, mem_q[15:0]};
            F3_W:    ld_val = mem_q;
            F3_BU:   ld_val = {24'd0, mem_q[7:0]};
            F3_HU:   ld_val = {16'd0, mem_q[15:0]};
            default: begin
                ld_val = mem_q;
                ld_ok  = 1'b0;
            end
        endcase
    end

    // register write ports
    assign clr   = fire1 && (s1_op == OP_RESTART);
    assign fp_we = fire2 && !r_s2_host && r_s2_float && (r_s2_f3 == F3_W);

    always_comb begin
        int_we = 1'b0;
        int_wa = res.rf_wa;
        int_wd = res.rf_wd;
        if (fire2) begin
            int_we = !r_s2_host && !r_s2_float && ld_ok && (r_s2_rd != REG_ZERO);
            int_wa = r_s2_rd;
            int_wd = ld_val;
        end else if (clr) begin
            int_we = 1'b1;
            int_wa = REG_LINK;
            int_wd = r_thread_index;
        end else if (fire1 && exec_live) begin
            int_we = res.rf_we;
        end
    end

    // next architectural state
    assign done_exec = (fire1 && exec_live) || (fire2 && !r_s2_host);

    always_comb begin
        if (clr) begin
            n_x17_one = 1'b0;
        end else if (int_we && int_wa == REG_EXIT) begin
            n_x17_one = (int_wd == 32'd1);
        end else begin
            n_x17_one = r_x17_one;
        end

        if (clr) begin
            n_running = 1'b1;
        end else if (done_exec) begin
            n_running = !n_x17_one;
        end else begin
            n_running = r_running;
        end

        if (clr) begin
            n_pc = r_start_pc;
        end else if ((fire1 || move12) && exec_live) begin
            n_pc = res.next_pc;
        end else begin
            n_pc = r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_running <= 1'b0;
            r_x17_one <= 1'b0;
        end else begin
            r_pc      <= n_pc;
            r_running <= n_running;
            r_x17_one <= n_x17_one;
        end
    end

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (fire1 || move12) begin
                r_s1_v <= 1'b0;
            end
            if (move12) begin
                r_s2_v <= 1'b1;
            end else if (fire2) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op    <= i_op;
            r_s1_instr <= i_instr;
            r_s1_haddr <= i_host_addr;
            r_s1_hdata <= i_host_data;
        end
        if (move12) begin
            r_s2_host  <= (s1_op == OP_HOST_RD);
            r_s2_float <= res.mem_rd_float;
            r_s2_f3    <= r_s1_instr[14:12];
            r_s2_rd    <= r_s1_instr[11:7];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (fire1 || fire2) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire1 || fire2) begin
            r_o_pc     <= n_pc;
            r_o_active <= n_running;
            r_o_exec   <= done_exec;
            r_o_rdata  <= (fire2 && r_s2_host) ? mem_q : 32'd0;
        end
    end

    assign o_valid       = r_ov;
    assign o_next_pc     = r_o_pc;
    assign o_lane_active = r_o_active;
    assign o_executed    = r_o_exec;
    assign o_read_data   = r_o_rdata;

    // stage 2 pending implies stage 1 is empty
    a_stage_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> !r_s1_v)
        else $error("both stages occupied");

    // x0 never written
    a_no_x0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int_we |-> (int_wa != REG_ZERO))
        else $error("write to x0");

    // restart leaves the lane running
    a_restart_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr |=> r_running)
        else $error("lane not running after restart");

    // one result per completion, never two at once
    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fire1 && fire2))
        else $error("two completions in one cycle");

endmodule

FILE: verif/testbench.sv
// testbench for the rv32i lane executor: random and directed request streams,
// checked against an in-bench model of the lane; depends on lnx_pkg and the RTL
`timescale 1ns / 1ps

module testbench;
    import lnx_pkg::*;

    localparam int          MEM_BYTES      = 4096;
    localparam logic        CFG_START_PC   = 1'b0;
    localparam logic        CFG_THREAD_IDX = 1'b1;
    localparam int          IDLE_PCT       = 9;
    localparam int          HOLD_CYCLES    = 200;
    localparam int          STALL_LIMIT    = 5000;
    localparam int          FILL_WORDS     = 64;

    typedef struct {
        t_op         op;
        logic [31:0] instr;
        logic [11:0] addr;
        logic [31:0] data;
    } t_request;

    typedef struct {
        logic [31:0] next_pc;
        logic        active;
        logic        executed;
        logic [31:0] rdata;
    } t_lane_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op = 2'd0;
    logic [31:0] i_instr = 32'd0;
    logic [11:0] i_host_addr = 12'd0;
    logic [31:0] i_host_data = 32'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_next_pc;
    logic        o_lane_active;
    logic        o_executed;
    logic [31:0] o_read_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = 32'd0;

    rv32i_lane_executor #(.DATA_MEM_BYTES(MEM_BYTES)) u_dut (.*);

    // lane model state
    logic [31:0] lane_pc;
    logic [31:0] xreg [32];
    logic [31:0] freg [32];
    logic        lane_running;
    logic [7:0]  lane_mem [MEM_BYTES];
    bit          byte_written [MEM_BYTES];
    logic [31:0] cfg_pc;
    logic [31:0] cfg_thread;

    t_request     request_q [$];
    t_lane_result result_q [$];
    t_request     cur_req;
    t_lane_result got_res;

    int unsigned req_cnt;
    int unsigned res_cnt;
    int unsigned mismatch_cnt;
    int unsigned stall_cnt;
    int unsigned hold_cnt;
    bit          held;
    int unsigned exec_cnt;
    int unsigned stop_cnt;

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] mem_word(input logic [31:0] addr);
        logic [31:0] v;
        logic [11:0] a;
        v = 32'd0;
        for (int k = 0; k < 4; k++) begin
            a = 12'(addr + k);
            v[8*k +: 8] = lane_mem[a];
        end
        return v;
    endfunction

    function automatic bit word_written(input logic [11:0] addr);
        bit ok;
        ok = 1'b1;
        for (int k = 0; k < 4; k++) ok &= byte_written[12'(addr + k)];
        return ok;
    endfunction

    task automatic mem_put(input logic [31:0] addr, input logic [31:0] v, input int nbytes);
        logic [11:0] a;
        for (int k = 0; k < nbytes; k++) begin
            a = 12'(addr + k);
            lane_mem[a] = v[8*k +: 8];
            byte_written[a] = 1'b1;
        end
    endtask

    task automatic set_x(input logic [4:0] rd, input logic [31:0] v);
        if (rd != REG_ZERO) xreg[rd] = v;
    endtask

    // one instruction on the model lane
    task automatic run_instr(input logic [31:0] ins);
        logic [6:0]  opc;
        logic [4:0]  rd, rs1, rs2, sh;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a, b, y, r, pc, link;
        logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
        bit          take, ok, is_imm;
        opc   = ins[6:0];
        rd    = ins[11:7];
        f3    = ins[14:12];
        rs1   = ins[19:15];
        rs2   = ins[24:20];
        f7    = ins[31:25];
        a     = xreg[rs1];
        b     = xreg[rs2];
        pc    = lane_pc;
        link  = pc + 32'd4;
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_u = {ins[31:12], 12'd0};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        lane_pc = link;
        take = 1'b0;
        ok = 1'b1;
        case (opc)
            OPC_LUI:   set_x(rd, imm_u);
            OPC_AUIPC: set_x(rd, pc + imm_u);
            OPC_JAL: begin
                set_x(rd, link);
                lane_pc = pc + imm_j;
            end
            OPC_JALR: begin
                lane_pc = (a + imm_i) & ~32'd1;
                set_x(rd, link);
            end
            OPC_BRANCH: begin
                case (f3)
                    F3_BEQ:  take = (a == b);
                    F3_BNE:  take = (a != b);
                    F3_BLT:  take = ($signed(a) < $signed(b));
                    F3_BGE:  take = !($signed(a) < $signed(b));
                    F3_BLTU: take = (a < b);
                    F3_BGEU: take = (a >= b);
                    default: ok = 1'b0;
                endcase
                if (ok && take) lane_pc = pc + imm_b;
            end
            OPC_LOAD: begin
                r = mem_word(a + imm_i);
                case (f3)
                    F3_B:    r = {{24{r[7]}}, r[7:0]};
                    F3_H:    r = {{16{r[15]}}, r[15:0]};
                    F3_W:    ;
                    F3_BU:   r = {24'd0, r[7:0]};
                    F3_HU:   r = {16'd0, r[15:0]};
                    default: ok = 1'b0;
                endcase
                if (ok) set_x(rd, r);
            end
            OPC_STORE: begin
                case (f3)
                    F3_B:    mem_put(a + imm_s, b, 1);
                    F3_H:    mem_put(a + imm_s, b, 2);
                    F3_W:    mem_put(a + imm_s, b, 4);
                    default: ;
                endcase
            end
            OPC_OPIMM, OPC_OP: begin
                is_imm = (opc == OPC_OPIMM);
                y  = is_imm ? imm_i : b;
                sh = is_imm ? rs2 : b[4:0];
                case (f3)
                    F3_ADD:  r = (!is_imm && f7 == F7_ALT) ? a - y : a + y;
                    F3_SLL:  r = a << sh;
                    F3_SLT:  r = ($signed(a) < $signed(y)) ? 32'd1 : 32'd0;
                    F3_SLTU: r = (a < y) ? 32'd1 : 32'd0;
                    F3_XOR:  r = a ^ y;
                    F3_SR:   r = (f7 == F7_ZERO) ? (a >> sh) : 32'($signed(a) >>> sh);
                    F3_OR:   r = a | y;
                    default: r = a & y;
                endcase
                set_x(rd, r);
            end
            OPC_SYSTEM: begin
                if (rd == REG_ZERO && rs1 == REG_ZERO && f3 == 3'd0) xreg[REG_EXIT] = 32'd1;
            end
            OPC_LOADFP: begin
                if (f3 == F3_W) freg[rd] = mem_word(a + imm_i);
            end
            OPC_STOREFP: begin
                if (f3 == F3_W) mem_put(a + imm_s, freg[rs2], 4);
            end
            default: ;
        endcase
    endtask

    // model one request, queue it with its expected result
    task automatic send(input t_op op, input logic [31:0] ins, input logic [11:0] addr,
                        input logic [31:0] data);
        t_request     rq;
        t_lane_result res;
        res.rdata = 32'd0;
        res.executed = 1'b0;
        case (op)
            OP_EXEC: begin
                if (lane_running) begin
                    run_instr(ins);
                    xreg[REG_ZERO] = 32'd0;
                    res.executed = 1'b1;
                    exec_cnt++;
                    if (xreg[REG_EXIT] == 32'd1) begin
                        lane_running = 1'b0;
                        stop_cnt++;
                    end
                end
            end
            OP_HOST_WR: mem_put({20'd0, addr}, data, 4);
            OP_HOST_RD: res.rdata = mem_word({20'd0, addr});
            default: begin
                lane_pc = cfg_pc;
                for (int k = 0; k < 32; k++) begin
                    xreg[k] = 32'd0;
                    freg[k] = 32'd0;
                end
                xreg[REG_LINK] = cfg_thread;
                lane_running = 1'b1;
            end
        endcase
        res.next_pc = lane_pc;
        res.active = lane_running;
        rq.op = op;
        rq.instr = ins;
        rq.addr = addr;
        rq.data = data;
        result_q.push_back(res);
        request_q.push_back(rq);
    endtask

    // loads always aim at the prefilled window so no unwritten byte is read
    function automatic logic [31:0] aim_load(input logic [31:0] ins);
        logic [11:0] tgt;
        logic [31:0] r;
        r = ins;
        if (ins[6:0] == OPC_LOAD || ins[6:0] == OPC_LOADFP) begin
            tgt = 12'($urandom_range(4 * FILL_WORDS - 4));
            r[31:20] = tgt - xreg[ins[19:15]][11:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] random_instr();
        logic [31:0] top;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        int unsigned pick;
        logic [31:0] ins;
        top  = $urandom;
        rd   = 5'($urandom);
        rs1  = 5'($urandom);
        rs2  = 5'($urandom);
        f3   = 3'($urandom);
        f7   = ($urandom_range(3) == 0) ? 7'($urandom) : (top[0] ? F7_ALT : F7_ZERO);
        pick = $urandom_range(99);
        if (pick < 6)        ins = {top[31:12], rd, OPC_LUI};
        else if (pick < 10)  ins = {top[31:12], rd, OPC_AUIPC};
        else if (pick < 14)  ins = {top[31:12], rd, OPC_JAL};
        else if (pick < 18)  ins = {top[31:20], rs1, 3'd0, rd, OPC_JALR};
        else if (pick < 28)  ins = {top[31:25], rs2, rs1, f3, top[11:7], OPC_BRANCH};
        else if (pick < 38)  ins = {top[31:20], rs1, f3, rd, OPC_LOAD};
        else if (pick < 48)  ins = {top[31:25], rs2, rs1, f3, top[11:7], OPC_STORE};
        else if (pick < 64)  ins = (f3 == F3_SLL || f3 == F3_SR) ?
                                   {f7, rs2, rs1, f3, rd, OPC_OPIMM} :
                                   {top[31:20], rs1, f3, rd, OPC_OPIMM};
        else if (pick < 82)  ins = {f7, rs2, rs1, f3, rd, OPC_OP};
        else if (pick < 84)  ins = {top[31:20], REG_ZERO, 3'd0, REG_ZERO, OPC_SYSTEM};
        else if (pick < 88)  ins = {top[31:20], rs1, top[0] ? F3_W : f3, rd, OPC_LOADFP};
        else if (pick < 92)  ins = {top[31:25], rs2, rs1, top[0] ? F3_W : f3, top[11:7],
                                    OPC_STOREFP};
        else                 ins = top;
        return aim_load(ins);
    endfunction

    task automatic wait_idle();
        while (request_q.size() != 0 || i_valid || result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_START_PC) cfg_pc = val;
        else cfg_thread = val;
    endtask

    task automatic random_phase(input int count);
        int unsigned pick;
        logic [11:0] a;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (!lane_running && $urandom_range(9) < 7) begin
                send(OP_RESTART, $urandom, 12'($urandom), $urandom);
            end else if (pick < 80) begin
                send(OP_EXEC, random_instr(), 12'($urandom), $urandom);
            end else if (pick < 88) begin
                a = pick[0] ? 12'($urandom) : 12'($urandom_range(4 * FILL_WORDS - 4));
                send(OP_HOST_WR, $urandom, a, $urandom);
            end else if (pick < 96) begin
                a = 12'($urandom);
                if (!word_written(a)) a = 12'($urandom_range(4 * FILL_WORDS - 4));
                send(OP_HOST_RD, $urandom, a, $urandom);
            end else begin
                send(OP_RESTART, $urandom, 12'($urandom), $urandom);
            end
        end
    endtask

    // stimulus
    initial begin
        lane_pc = 32'd0;
        lane_running = 1'b0;
        cfg_pc = 32'd0;
        cfg_thread = 32'd0;
        for (int k = 0; k < 32; k++) begin
            xreg[k] = 32'd0;
            freg[k] = 32'd0;
        end
        for (int k = 0; k < MEM_BYTES; k++) begin
            lane_mem[k] = 8'd0;
            byte_written[k] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: stopped lane, host extremes, corner instructions
        cfg_write(CFG_START_PC, 32'h0000_0100);
        cfg_write(CFG_THREAD_IDX, 32'h8000_0007);
        send(OP_EXEC, {12'd5, REG_ZERO, F3_ADD, REG_LINK, OPC_OPIMM}, 12'd0, 32'd0);
        for (int w = 0; w < FILL_WORDS; w++)
            send(OP_HOST_WR, 32'd0, 12'(4 * w), $urandom);
        send(OP_HOST_WR, 32'd0, 12'hFFE, 32'hFFFF_FFFF);
        send(OP_HOST_RD, 32'd0, 12'hFFF, 32'd0);
        send(OP_HOST_RD, 32'd0, 12'hFFE, 32'd0);
        send(OP_HOST_WR, 32'd0, 12'h010, 32'h8081_7F80);
        send(OP_RESTART, 32'd0, 12'd0, 32'd0);
        send(OP_EXEC, {20'hFFFFF, 5'd2, OPC_LUI}, 12'd0, 32'd0);
        send(OP_EXEC, {7'd0, 5'd1, 5'd2, F3_ADD, 5'd3, OPC_OP}, 12'd0, 32'd0);
        send(OP_EXEC, {F7_ALT, 5'd1, 5'd2, F3_ADD, 5'd4, OPC_OP}, 12'd0, 32'd0);
        send(OP_EXEC, {F7_ALT, 5'd31, 5'd2, F3_SR, 5'd5, OPC_OPIMM}, 12'd0, 32'd0);
        send(OP_EXEC, {F7_ZERO, 5'd31, 5'd2, F3_SR, 5'd6, OPC_OPIMM}, 12'd0, 32'd0);
        send(OP_EXEC, {7'd0, 5'd2, 5'd1, F3_SLT, 5'd7, OPC_OP}, 12'd0, 32'd0);
        send(OP_EXEC, {12'h7FF, 5'd2, F3_ADD, REG_ZERO, OPC_OPIMM}, 12'd0, 32'd0);
        send(OP_EXEC, aim_load({12'd0, REG_ZERO, F3_B, 5'd8, OPC_LOAD}), 12'd0, 32'd0);
        send(OP_EXEC, aim_load({12'd0, REG_ZERO, F3_W, 5'd0, OPC_LOADFP}), 12'd0, 32'd0);
        send(OP_EXEC, {7'd0, 5'd0, REG_ZERO, F3_W, 5'd20, OPC_STOREFP}, 12'd0, 32'd0);
        send(OP_EXEC, {7'h7F, 5'd0, 5'd0, F3_BEQ, 5'h1F, OPC_BRANCH}, 12'd0, 32'd0);
        send(OP_EXEC, {12'h801, 5'd2, 3'd0, 5'd9, OPC_JALR}, 12'd0, 32'd0);
        send(OP_EXEC, {20'h80000, 5'd10, OPC_JAL}, 12'd0, 32'd0);
        send(OP_EXEC, {12'd0, REG_ZERO, 3'd0, REG_ZERO, OPC_SYSTEM}, 12'd0, 32'd0);
        send(OP_EXEC, {20'h12345, 5'd2, OPC_LUI}, 12'd0, 32'd0);
        random_phase(60);

        // random phases under different lane settings
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            case (p)
                0:       begin cfg_write(CFG_START_PC, 32'd0); cfg_write(CFG_THREAD_IDX, 32'd0); end
                1:       begin
                    cfg_write(CFG_START_PC, 32'hFFFF_FFFF);
                    cfg_write(CFG_THREAD_IDX, 32'hFFFF_FFFF);
                end
                default: begin
                    cfg_write(CFG_START_PC, $urandom);
                    cfg_write(CFG_THREAD_IDX, $urandom);
                end
            endcase
            send(OP_RESTART, $urandom, 12'($urandom), $urandom);
            random_phase(240);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("covered %0d requests, %0d instructions executed, %0d lane stops",
                 req_cnt, exec_cnt, stop_cnt);
        $display("%0d results checked, %0d mismatches", res_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && result_q.size() == 0) begin
            $display("[rv32i_lane_executor] OK");
        end else begin
            $display("[rv32i_lane_executor] ERROR");
        end
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) req_cnt <= req_cnt + 1;
            if (request_q.size() != 0 &&
                ((res_cnt > 500 && res_cnt < 750) || $urandom_range(99) >= IDLE_PCT)) begin
                cur_req = request_q.pop_front();
                i_valid     <= 1'b1;
                i_op        <= cur_req.op;
                i_instr     <= cur_req.instr;
                i_host_addr <= cur_req.addr;
                i_host_data <= cur_req.data;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready <= 1'b0;
        end else if (!held && res_cnt >= 300) begin
            held <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            i_ready <= 1'b0;
        end else begin
            i_ready <= (res_cnt > 500 && res_cnt < 750) || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            res_cnt <= res_cnt + 1;
            if (result_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result, pc %h", o_next_pc);
            end else begin
                got_res = result_q.pop_front();
                if (o_next_pc !== got_res.next_pc || o_lane_active !== got_res.active ||
                    o_executed !== got_res.executed || o_read_data !== got_res.rdata) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("result %0d: exp pc %h act %b exe %b rd %h, got %h %b %b %h",
                                 res_cnt, got_res.next_pc, got_res.active, got_res.executed,
                                 got_res.rdata, o_next_pc, o_lane_active, o_executed,
                                 o_read_data);
                end
            end
        end
    end

    // watchdog on stalled handshakes
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("[rv32i_lane_executor] ERROR");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        req_cnt = 0;
        res_cnt = 0;
        mismatch_cnt = 0;
        stall_cnt = 0;
        hold_cnt = 0;
        held = 1'b0;
        exec_cnt = 0;
        stop_cnt = 0;
    end

endmodule

FILE: files.f
design/lnx_pkg.sv
design/lnx_regfile.sv
design/lnx_dmem.sv
design/lnx_exec.sv
design/rv32i_lane_executor.sv
verif/testbench.sv
